FILE: sv/bafs_pkg.sv
// Shared types and constants for the beacon advertisement filter.
`timescale 1ns / 1ps

package bafs_pkg;

  typedef enum logic [1:0] {
    ACT_BYTE   = 2'd0,
    ACT_START  = 2'd1,
    ACT_REPORT = 2'd2
  } action_t;

  localparam int unsigned PREFIX_LEN     = 9;
  localparam int unsigned UUID_END       = 25;
  localparam int unsigned MIN_PACKET_LEN = 29;
  localparam logic [4:0]  POS_MAX        = 5'd31;

  localparam logic [63:0] UUID_HIGH_RESET = 64'hFDA5_0693_A4E2_4FB1;
  localparam logic [63:0] UUID_LOW_RESET  = 64'hAFCF_C6EB_0764_7825;

  localparam logic [1:0] CFG_UUID_HIGH = 2'd0;
  localparam logic [1:0] CFG_UUID_LOW  = 2'd1;

  // Per-byte verdict from the byte checker.
  typedef struct packed {
    logic       mismatch;  // byte differs from the expected prefix/UUID byte
    logic       capture;   // byte is one of the major/minor bytes
    logic [1:0] id_sel;    // 0 = major high byte ... 3 = minor low byte
  } parse_t;

  // Fixed advertisement prefix: flags, manufacturer data header, beacon type.
  function automatic logic [7:0] prefix_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h02;
      4'd1:    b = 8'h01;
      4'd2:    b = 8'h06;
      4'd3:    b = 8'h1A;
      4'd4:    b = 8'hFF;
      4'd5:    b = 8'h4C;
      4'd6:    b = 8'h00;
      4'd7:    b = 8'h02;
      4'd8:    b = 8'h15;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: sv/bafs_byte_check.sv
// Compares one payload byte against the expected prefix or UUID byte at its position.
`timescale 1ns / 1ps

module bafs_byte_check (
  input  logic [4:0]      pos,
  input  logic [7:0]      data_byte,
  input  logic [63:0]     uuid_high,
  input  logic [63:0]     uuid_low,
  output bafs_pkg::parse_t verdict
);

  logic [127:0] uuid_all;
  logic [4:0]   uuid_off;
  logic [3:0]   uuid_idx;
  logic [4:0]   id_off;
  logic [7:0]   uuid_byte;

  assign uuid_all  = {uuid_high, uuid_low};
  assign uuid_off  = pos - 5'(bafs_pkg::PREFIX_LEN);
  assign uuid_idx  = uuid_off[3:0];
  assign id_off    = pos - 5'(bafs_pkg::UUID_END);
  // UUID byte 0 sits in the top byte of the high word
  assign uuid_byte = uuid_all[{~uuid_idx, 3'b000} +: 8];

  always_comb begin
    verdict = '0;
    verdict.id_sel = id_off[1:0];
    if (pos < 5'(bafs_pkg::PREFIX_LEN)) begin
      verdict.mismatch = (data_byte != bafs_pkg::prefix_byte(pos[3:0]));
    end else if (pos < 5'(bafs_pkg::UUID_END)) begin
      verdict.mismatch = (data_byte != uuid_byte);
    end else if (pos < 5'(bafs_pkg::MIN_PACKET_LEN)) begin
      verdict.capture = 1'b1;
    end
  end

endmodule

FILE: sv/beacon_adv_filter_strongest.sv
// Top level: beacon advertisement parser keeping the strongest matching beacon.
//
//  channel   | dir | handshake                      | payload
//  s_axis    | in  | s_axis_tvalid / s_axis_tready  | tdata {rssi, byte}, tlast, tuser action
//  m_axis    | out | m_axis_tvalid / m_axis_tready  | tdata {rssi, minor, major}, tuser found
//  cfg       | in  | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// One item per cycle while no report stalls. An item is registered at accept and
// processed against the parser state from the input register; a report result is
// loaded into the output register at the end of the cycle in which it is processed.
// Reset restores the default UUID and clears parser and best state.
// A report waiting in the input register stalls only while the output register
// holds a result that is not taken; other items never stall.
`timescale 1ns / 1ps

module beacon_adv_filter_strongest (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [15:8] packet_rssi
  input  logic        s_axis_tlast,   // last_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [15:0] best_major, [31:16] best_minor, [39:32] best_rssi
  output logic        m_axis_tuser,   // [0] found
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // configuration
  logic [63:0] uuid_high;
  logic [63:0] uuid_low;

  // input register
  logic              in_valid;
  logic [1:0]        in_action;
  logic [7:0]        in_data;
  logic              in_last;
  logic signed [7:0] in_rssi;

  // parser and best state
  logic [4:0]        byte_position, byte_position_next;
  logic              still_matching, still_matching_next;
  logic [31:0]       captured_ids, captured_ids_next;
  logic              have_best, have_best_next;
  logic signed [7:0] kept_rssi, kept_rssi_next;
  logic [15:0]       kept_major, kept_major_next;
  logic [15:0]       kept_minor, kept_minor_next;

  logic             out_free;
  logic             is_report;
  logic             advance;
  logic             s_accept;
  bafs_pkg::parse_t verdict;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      uuid_high <= bafs_pkg::UUID_HIGH_RESET;
      uuid_low  <= bafs_pkg::UUID_LOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bafs_pkg::CFG_UUID_HIGH) begin
        uuid_high <= cfg_data;
      end else if (cfg_index == bafs_pkg::CFG_UUID_LOW) begin
        uuid_low <= cfg_data;
      end
    end
  end

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign is_report     = (in_action == bafs_pkg::ACT_REPORT);
  assign advance       = in_valid && (!is_report || out_free);
  assign s_axis_tready = !in_valid || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_action <= s_axis_tuser;
      in_data   <= s_axis_tdata[7:0];
      in_rssi   <= s_axis_tdata[15:8];
      in_last   <= s_axis_tlast;
    end
  end

  bafs_byte_check u_check (
    .pos       (byte_position),
    .data_byte (in_data),
    .uuid_high (uuid_high),
    .uuid_low  (uuid_low),
    .verdict   (verdict)
  );

  always_comb begin
    byte_position_next  = byte_position;
    still_matching_next = still_matching;
    captured_ids_next   = captured_ids;
    have_best_next      = have_best;
    kept_rssi_next      = kept_rssi;
    kept_major_next     = kept_major;
    kept_minor_next     = kept_minor;
    if (advance) begin
      case (bafs_pkg::action_t'(in_action))
        bafs_pkg::ACT_BYTE: begin
          if (verdict.mismatch) begin
            still_matching_next = 1'b0;
          end
          if (verdict.capture) begin
            captured_ids_next[{~verdict.id_sel, 3'b000} +: 8] = in_data;
          end
          if (in_last) begin
            // packet long enough to have carried all four id bytes
            if (still_matching_next &&
                byte_position >= 5'(bafs_pkg::MIN_PACKET_LEN - 1) &&
                (!have_best || in_rssi > kept_rssi)) begin
              have_best_next  = 1'b1;
              kept_rssi_next  = in_rssi;
              kept_major_next = captured_ids_next[31:16];
              kept_minor_next = captured_ids_next[15:0];
            end
            byte_position_next  = '0;
            still_matching_next = 1'b1;
          end else if (byte_position != bafs_pkg::POS_MAX) begin
            byte_position_next = byte_position + 5'd1;
          end
        end
        bafs_pkg::ACT_START: begin
          have_best_next      = 1'b0;
          byte_position_next  = '0;
          still_matching_next = 1'b1;
        end
        default: begin
          // report reads state only; unused code is ignored
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      still_matching <= 1'b1;
      captured_ids   <= '0;
      have_best      <= 1'b0;
      kept_rssi      <= '0;
      kept_major     <= '0;
      kept_minor     <= '0;
    end else begin
      byte_position  <= byte_position_next;
      still_matching <= still_matching_next;
      captured_ids   <= captured_ids_next;
      have_best      <= have_best_next;
      kept_rssi      <= kept_rssi_next;
      kept_major     <= kept_major_next;
      kept_minor     <= kept_minor_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && is_report) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_report) begin
      m_axis_tuser <= have_best;
      if (have_best) begin
        m_axis_tdata <= {kept_rssi, kept_minor, kept_major};
      end else begin
        m_axis_tdata <= '0;
      end
    end
  end

endmodule

FILE: sv/bafs_checker.sv
// Port-level checks for the beacon advertisement filter, bound to the top level.
`timescale 1ns / 1ps

module bafs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a result waiting to be taken holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // empty report carries zero payload
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("not-found result with nonzero payload");

  // input never blocked while the result register can take an item
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled with free result register");

  // a fresh result comes from an accepted report item
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready &&
            s_axis_tuser == bafs_pkg::ACT_REPORT, 2))
    else $error("result without a matching report item");

endmodule

bind beacon_adv_filter_strongest bafs_checker u_bafs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: bench/tb_beacon_adv_filter_strongest.sv
// Testbench for beacon_adv_filter_strongest: random advertisement streams against a predictor.
`timescale 1ns / 1ps

class strongest_beacon_check;
  typedef struct packed {
    logic        found;
    logic [15:0] major;
    logic [15:0] minor;
    logic [7:0]  rssi;
  } beacon_report_t;

  logic [7:0] adv_prefix [9] = '{8'h02, 8'h01, 8'h06, 8'h1A, 8'hFF, 8'h4C, 8'h00, 8'h02, 8'h15};

  logic [63:0]        uuid_high;
  logic [63:0]        uuid_low;
  logic [4:0]         byte_pos;
  logic               matching;
  logic [31:0]        ids;
  logic               have_best;
  logic signed [7:0]  best_rssi;
  logic [15:0]        best_major;
  logic [15:0]        best_minor;
  beacon_report_t     expected_reports[$];
  int                 errors;

  function new();
    uuid_high  = bafs_pkg::UUID_HIGH_RESET;
    uuid_low   = bafs_pkg::UUID_LOW_RESET;
    byte_pos   = '0;
    matching   = 1'b1;
    ids        = '0;
    have_best  = 1'b0;
    best_rssi  = '0;
    best_major = '0;
    best_minor = '0;
    errors     = 0;
  endfunction

  // Byte a matching beacon carries at positions 0..24.
  function logic [7:0] match_byte(int pos);
    logic [127:0] uuid;
    uuid = {uuid_high, uuid_low};
    if (pos < bafs_pkg::PREFIX_LEN) return adv_prefix[pos];
    return uuid[8*(bafs_pkg::UUID_END-1-pos) +: 8];
  endfunction

  function void set_register(logic [1:0] idx, logic [63:0] val);
    if (idx == bafs_pkg::CFG_UUID_HIGH) uuid_high = val;
    else if (idx == bafs_pkg::CFG_UUID_LOW) uuid_low = val;
  endfunction

  function void note_item(logic [1:0] act, logic [7:0] data, logic last, logic [7:0] rssi);
    beacon_report_t r;
    case (act)
      bafs_pkg::ACT_BYTE: begin
        if (byte_pos < bafs_pkg::UUID_END) begin
          if (data != match_byte(byte_pos)) matching = 1'b0;
        end else if (byte_pos < bafs_pkg::MIN_PACKET_LEN) begin
          ids[8*(bafs_pkg::MIN_PACKET_LEN-1-byte_pos) +: 8] = data;
        end
        if (last) begin
          if (matching && byte_pos >= bafs_pkg::MIN_PACKET_LEN - 1 &&
              (!have_best || $signed(rssi) > best_rssi)) begin
            have_best  = 1'b1;
            best_rssi  = rssi;
            best_major = ids[31:16];
            best_minor = ids[15:0];
          end
          byte_pos = '0;
          matching = 1'b1;
        end else if (byte_pos != bafs_pkg::POS_MAX) begin
          byte_pos = byte_pos + 5'd1;
        end
      end
      bafs_pkg::ACT_START: begin
        have_best = 1'b0;
        byte_pos  = '0;
        matching  = 1'b1;
      end
      bafs_pkg::ACT_REPORT: begin
        r.found = have_best;
        r.major = have_best ? best_major : 16'h0;
        r.minor = have_best ? best_minor : 16'h0;
        r.rssi  = have_best ? best_rssi : 8'h0;
        expected_reports.push_back(r);
      end
      default: ;  // unused action code: no effect
    endcase
  endfunction

  task report(string msg);
    $display("%0t ERROR: %s", $time, msg);
    errors++;
  endtask

  task check_report(logic found, logic [15:0] major, logic [15:0] minor, logic [7:0] rssi);
    beacon_report_t exp_r;
    if (expected_reports.size() == 0) begin
      report("result with no report pending");
      return;
    end
    exp_r = expected_reports.pop_front();
    if (found !== exp_r.found)
      report($sformatf("found %0b, expected %0b", found, exp_r.found));
    if (major !== exp_r.major)
      report($sformatf("best_major %04h, expected %04h", major, exp_r.major));
    if (minor !== exp_r.minor)
      report($sformatf("best_minor %04h, expected %04h", minor, exp_r.minor));
    if (rssi !== exp_r.rssi)
      report($sformatf("best_rssi %02h, expected %02h", rssi, exp_r.rssi));
  endtask
endclass

module tb_beacon_adv_filter_strongest;
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  strongest_beacon_check sb;
  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int reports_sent = 0;

  beacon_adv_filter_strongest dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tlast, s_axis_tdata[15:8]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_report(m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                        m_axis_tdata[39:32]);
    end
  end

  task automatic send_item(logic [1:0] act, logic [7:0] data, logic last, logic [7:0] rssi);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rssi, data};
    s_axis_tlast  <= last;
    s_axis_tuser  <= act;
    do @(posedge clk); while (!s_axis_tready);
    if (act != ACT_IGNORED) items_sent++;
    if (act == bafs_pkg::ACT_REPORT) reports_sent++;
  endtask

  // Hold off the sender until every pending report has come out.
  task automatic drain_reports();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_rssi();
    case ($urandom_range(4))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'hC4;  // repeated value so equal RSSIs meet
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_report();
    send_item(bafs_pkg::ACT_REPORT, 8'($urandom_range(255)), 1'($urandom_range(1)),
              8'($urandom_range(255)));
  endtask

  task automatic send_packet();
    int kind, len, bad_pos, p;
    logic noise, cut;
    logic [7:0] rssi, b, r;
    kind    = $urandom_range(99);
    len     = bafs_pkg::MIN_PACKET_LEN;
    bad_pos = -1;
    noise   = 1'b0;
    cut     = 1'b0;
    if (kind >= 55 && kind < 65) len = $urandom_range(30, 40);
    else if (kind >= 65 && kind < 75) len = $urandom_range(1, 28);
    else if (kind >= 75 && kind < 85) bad_pos = $urandom_range(0, 24);
    else if (kind >= 85 && kind < 92) begin
      noise = 1'b1;
      len   = $urandom_range(1, 35);
    end else if (kind >= 92) begin
      cut = 1'b1;
      len = $urandom_range(1, 30);
    end
    rssi = pick_rssi();
    for (p = 0; p < len; p++) begin
      if (noise || p >= bafs_pkg::UUID_END) b = 8'($urandom_range(255));
      else b = sb.match_byte(p);
      if (p == bad_pos) b = b ^ 8'($urandom_range(1, 255));
      // only the last byte's RSSI counts; vary the others now and then
      r = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : rssi;
      send_item(bafs_pkg::ACT_BYTE, b, (p == len - 1) && !cut, (p == len - 1) ? rssi : r);
      if ($urandom_range(99) < 3) send_report();
      if ($urandom_range(99) < 2)
        send_item(ACT_IGNORED, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  8'($urandom_range(255)));
    end
    if (cut)
      send_item(bafs_pkg::ACT_START, 8'($urandom_range(255)), 1'($urandom_range(1)), 8'h00);
  endtask

  task automatic random_phase(int item_goal, int report_goal);
    int item_end, report_end, n;
    item_end   = items_sent + item_goal;
    report_end = reports_sent + report_goal;
    while (items_sent < item_end || reports_sent < report_end) begin
      send_packet();
      n = $urandom_range(2);
      repeat (n) send_report();
      if ($urandom_range(99) < 10)
        send_item(bafs_pkg::ACT_START, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  8'($urandom_range(255)));
      if (n != 0 && $urandom_range(7) == 0) drain_reports();
    end
    drain_reports();
  endtask

  initial begin
    sb            = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tuser  = bafs_pkg::ACT_BYTE;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = bafs_pkg::CFG_UUID_HIGH;
    cfg_data      = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty window, ignored action, short and broken packets
    send_item(bafs_pkg::ACT_REPORT, 8'h00, 1'b0, 8'h00);
    send_item(ACT_IGNORED, 8'h00, 1'b0, 8'h00);
    send_item(bafs_pkg::ACT_BYTE, 8'h02, 1'b1, 8'h7F);
    send_item(bafs_pkg::ACT_REPORT, 8'hFF, 1'b1, 8'hFF);
    send_item(bafs_pkg::ACT_START, 8'hFF, 1'b0, 8'h80);
    send_item(bafs_pkg::ACT_REPORT, 8'h00, 1'b0, 8'h00);
    send_item(bafs_pkg::ACT_BYTE, 8'hFF, 1'b0, 8'h80);
    send_item(bafs_pkg::ACT_BYTE, 8'h00, 1'b1, 8'h80);
    send_item(bafs_pkg::ACT_REPORT, 8'h00, 1'b0, 8'h00);
    send_item(ACT_IGNORED, 8'hFF, 1'b1, 8'hFF);
    send_item(bafs_pkg::ACT_REPORT, 8'h00, 1'b0, 8'h00);
    drain_reports();

    // default UUID, no idling
    random_phase(110, 6);

    cfg_write(bafs_pkg::CFG_UUID_HIGH, 64'h0);
    cfg_write(bafs_pkg::CFG_UUID_LOW, 64'h0);
    idle_pct = 66;
    random_phase(110, 6);

    cfg_write(bafs_pkg::CFG_UUID_HIGH, '1);
    cfg_write(bafs_pkg::CFG_UUID_LOW, '1);
    idle_pct  = 0;
    stall_pct = 66;
    random_phase(110, 6);

    cfg_write(bafs_pkg::CFG_UUID_LOW, {$urandom, $urandom});
    cfg_write(bafs_pkg::CFG_UUID_HIGH, {$urandom, $urandom});
    idle_pct  = 9;
    stall_pct = 9;
    random_phase(110, 6);

    if (sb.errors == 0) begin
      $display("tb_beacon_adv_filter_strongest: PASS");
    end else begin
      $display("tb_beacon_adv_filter_strongest: FAIL");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_beacon_adv_filter_strongest: FAIL");
    $finish;
  end
endmodule
